@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check with active-low reset disable
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sgcm_pkg.sv @@
// ----------------------------------------------------------------------------
// sgcm_pkg
// Shared types, constants and functions for the SM4-GCM encryptor.
// ----------------------------------------------------------------------------
package sgcm_pkg;

    localparam int DataW  = 64;
    localparam int CntW   = 5;
    localparam int TotalW = 36;
    localparam int FifoDepthDef = 2;
    // result word: two data halves, byte count, kind, last flag
    localparam int ResW   = 2*DataW + CntW + 2;

    localparam logic [63:0] GcmR = 64'hE100000000000000;
    localparam logic [31:0] Fk0 = 32'ha3b1bac6;
    localparam logic [31:0] Fk1 = 32'h56aa3350;
    localparam logic [31:0] Fk2 = 32'h677d9197;
    localparam logic [31:0] Fk3 = 32'hb27022dc;

    localparam logic [3:0] IdxKeyHigh = 4'd0;
    localparam logic [3:0] IdxKeyLow  = 4'd1;
    localparam logic [3:0] IdxIvHigh  = 4'd2;
    localparam logic [3:0] IdxIvLow   = 4'd3;

    // Request from front to back
    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;   // saturated to 16
        logic        last_block;
        logic        start;        // first item of a message
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEYEXP,
        ST_ENC_H,
        ST_ENC_J0,
        ST_ENC_CTR,
        ST_GH_DATA,
        ST_OUT_DATA,
        ST_GH_LEN,
        ST_OUT_TAG
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] a);
        return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    endfunction

    // Round constant: byte j is (4*i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [4:0] i);
        logic [7:0] b0;
        b0 = {1'b0, i, 2'b00} * 8'd7;
        return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

    // Leading-byte mask for n valid bytes (n at most 16)
    function automatic logic [127:0] lead_mask(input logic [4:0] n);
        logic [127:0] m;
        m = '0;
        for (int k = 0; k < 16; k++) begin
            if (5'(k) < n) begin
                m[127 - 8*k -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ rtl/core/sgcm_fifo.sv @@
// ----------------------------------------------------------------------------
// sgcm_fifo
// Small register queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module sgcm_fifo
    import sgcm_pkg::*;
#(
    parameter int Width = 8,
    parameter int Depth = FifoDepthDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [Width-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    logic [Width-1:0] r_mem [Depth];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

`include "assert_macros.svh"
    `CHK_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(Depth), "fifo count overflow")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, !w_wr && !w_rd, $stable(r_cnt), "fifo count moved")
endmodule

@@ rtl/core/sgcm_front.sv @@
// ----------------------------------------------------------------------------
// sgcm_front
// Accepts items, saturates the byte count, marks message starts.
// ----------------------------------------------------------------------------
module sgcm_front
    import sgcm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic [4:0]  i_byte_count,
    input  logic        i_last_block,
    output logic        o_req_push,
    output t_req        o_req,
    input  logic        i_req_full
);
    logic r_in_msg;
    logic w_acc;

    assign o_full     = i_req_full;
    assign w_acc      = i_push && !i_req_full;
    assign o_req_push = i_push;

    // classify
    always_comb begin
        o_req.data_high  = i_data_high;
        o_req.data_low   = i_data_low;
        o_req.byte_count = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
        o_req.last_block = i_last_block;
        o_req.start      = !r_in_msg;
    end

    // message tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else if (w_acc) begin
            r_in_msg <= !i_last_block;
        end
    end

`include "assert_macros.svh"
    `CHK_NEXT(a_msg_end, i_clk, i_rst_n, w_acc && i_last_block, !r_in_msg, "message not closed")
endmodule

@@ rtl/core/sgcm_back.sv @@
// ----------------------------------------------------------------------------
// sgcm_back
// Round-serial SM4 engine, key expansion and bit-serial GHASH sequencer.
// ----------------------------------------------------------------------------
module sgcm_back
    import sgcm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_key_high,
    input  logic [63:0] i_key_low,
    input  logic [63:0] i_iv_high,
    input  logic [31:0] i_iv_low,
    input  logic        i_req_empty,
    input  t_req        i_req,
    output logic        o_req_pop,
    output logic        o_res_push,
    output logic [ResW-1:0] o_res,
    input  logic        i_res_full
);
    t_state r_state, n_state;
    logic [4:0]   r_rnd;
    logic [6:0]   r_bit;
    logic [31:0]  r_x0, r_x1, r_x2, r_x3;
    logic [31:0]  r_rk [32];
    logic [127:0] r_h, r_mask, r_acc, r_z, r_v, r_y, r_ct;
    logic [31:0]  r_ctr;
    logic [TotalW-1:0] r_total;

    logic [31:0]  w_t, w_b, w_l, w_rkx, w_nx;
    logic [127:0] w_blk, w_ct_n, w_v_n;
    logic         w_done;

    // round function shared by key expansion and encryption
    assign w_t   = r_x1 ^ r_x2 ^ r_x3 ^ ((r_state == ST_KEYEXP) ? ck_word(r_rnd) : r_rk[r_rnd]);
    assign w_b   = tau(w_t);
    assign w_rkx = r_x0 ^ w_b ^ {w_b[18:0], w_b[31:19]} ^ {w_b[8:0], w_b[31:9]};
    assign w_l   = r_x0 ^ w_b ^ {w_b[29:0], w_b[31:30]} ^ {w_b[21:0], w_b[31:22]}
                 ^ {w_b[13:0], w_b[31:14]} ^ {w_b[7:0], w_b[31:8]};
    assign w_nx  = (r_state == ST_KEYEXP) ? w_rkx : w_l;
    assign w_blk = {w_nx, r_x3, r_x2, r_x1};
    assign w_done = (r_rnd == 5'd31);
    assign w_ct_n = {i_req.data_high, i_req.data_low} ^ w_blk;
    assign w_v_n  = {1'b0, r_v[127:1]} ^ (r_v[0] ? {GcmR, 64'd0} : 128'd0);

    // next state
    always_comb begin
        n_state    = r_state;
        o_req_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        case (r_state)
            ST_IDLE: begin
                if (!i_req_empty) begin
                    if (i_req.start) begin
                        n_state = ST_KEYEXP;
                    end else if (i_req.byte_count != 5'd0) begin
                        n_state = ST_ENC_CTR;
                    end else if (i_req.last_block) begin
                        n_state = ST_GH_LEN;
                    end else begin
                        o_req_pop = 1'b1;
                    end
                end
            end
            ST_KEYEXP: if (w_done) n_state = ST_ENC_H;
            ST_ENC_H:  if (w_done) n_state = ST_ENC_J0;
            ST_ENC_J0: begin
                if (w_done) begin
                    if (i_req.byte_count != 5'd0) begin
                        n_state = ST_ENC_CTR;
                    end else if (i_req.last_block) begin
                        n_state = ST_GH_LEN;
                    end else begin
                        n_state   = ST_IDLE;
                        o_req_pop = 1'b1;
                    end
                end
            end
            ST_ENC_CTR: if (w_done) n_state = ST_GH_DATA;
            ST_GH_DATA: if (r_bit == 7'd127) n_state = ST_OUT_DATA;
            ST_OUT_DATA: begin
                o_res_push = 1'b1;
                o_res = {r_ct, i_req.byte_count, 1'b0, !i_req.last_block};
                if (!i_res_full) begin
                    if (i_req.last_block) begin
                        n_state = ST_GH_LEN;
                    end else begin
                        n_state   = ST_IDLE;
                        o_req_pop = 1'b1;
                    end
                end
            end
            ST_GH_LEN: if (r_bit == 7'd127) n_state = ST_OUT_TAG;
            ST_OUT_TAG: begin
                o_res_push = 1'b1;
                o_res = {r_acc ^ r_mask, 5'd16, 1'b1, 1'b1};
                if (!i_res_full) begin
                    n_state   = ST_IDLE;
                    o_req_pop = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control counters and message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd   <= '0;
            r_bit   <= '0;
            r_ctr   <= '0;
            r_total <= '0;
            r_acc   <= '0;
        end else begin
            if (r_state == ST_KEYEXP || r_state == ST_ENC_H || r_state == ST_ENC_J0
                || r_state == ST_ENC_CTR) begin
                r_rnd <= r_rnd + 5'd1;
            end else begin
                r_rnd <= '0;
            end
            if (r_state == ST_GH_DATA || r_state == ST_GH_LEN) begin
                r_bit <= r_bit + 7'd1;
            end else begin
                r_bit <= '0;
            end
            if (r_state == ST_ENC_J0 && w_done) begin
                r_ctr   <= 32'd2;
                r_total <= '0;
                r_acc   <= '0;
            end
            if (r_state == ST_ENC_CTR && w_done) begin
                r_ctr   <= r_ctr + 32'd1;
                r_total <= r_total + TotalW'(i_req.byte_count);
            end
            if ((r_state == ST_GH_DATA || r_state == ST_GH_LEN) && r_bit == 7'd127) begin
                r_acc <= r_z ^ (r_y[127] ? r_v : 128'd0);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_req_empty && i_req.start) begin
                    r_x0 <= i_key_high[63:32] ^ Fk0;
                    r_x1 <= i_key_high[31:0] ^ Fk1;
                    r_x2 <= i_key_low[63:32] ^ Fk2;
                    r_x3 <= i_key_low[31:0] ^ Fk3;
                end else begin
                    {r_x0, r_x1, r_x2, r_x3} <= {i_iv_high, i_iv_low, r_ctr};
                end
            end
            ST_KEYEXP: begin
                r_rk[r_rnd] <= w_rkx;
                {r_x0, r_x1, r_x2, r_x3} <= w_done ? 128'd0 : {r_x1, r_x2, r_x3, w_nx};
            end
            ST_ENC_H: begin
                if (w_done) begin
                    r_h <= w_blk;
                    {r_x0, r_x1, r_x2, r_x3} <= {i_iv_high, i_iv_low, 32'd1};
                end else begin
                    {r_x0, r_x1, r_x2, r_x3} <= {r_x1, r_x2, r_x3, w_nx};
                end
            end
            ST_ENC_J0: begin
                if (w_done) begin
                    r_mask <= w_blk;
                    {r_x0, r_x1, r_x2, r_x3} <= {i_iv_high, i_iv_low, 32'd2};
                    // empty message: fresh accumulator and zero length, so a zero block
                    r_z <= '0;
                    r_v <= r_h;
                    r_y <= '0;
                end else begin
                    {r_x0, r_x1, r_x2, r_x3} <= {r_x1, r_x2, r_x3, w_nx};
                end
            end
            ST_ENC_CTR: begin
                if (w_done) begin
                    r_ct <= w_ct_n & lead_mask(i_req.byte_count);
                    r_y  <= r_acc ^ (w_ct_n & lead_mask(i_req.byte_count));
                    r_z  <= '0;
                    r_v  <= r_h;
                end else begin
                    {r_x0, r_x1, r_x2, r_x3} <= {r_x1, r_x2, r_x3, w_nx};
                end
            end
            ST_GH_DATA, ST_GH_LEN: begin
                r_z <= r_z ^ (r_y[127] ? r_v : 128'd0);
                r_v <= w_v_n;
                r_y <= {r_y[126:0], 1'b0};
            end
            ST_OUT_DATA: begin
                r_z <= '0;
                r_v <= r_h;
                r_y <= r_acc ^ {64'd0, 25'd0, r_total, 3'd0};
            end
            default: begin
                if (n_state == ST_GH_LEN) begin
                    r_z <= '0;
                    r_v <= r_h;
                    r_y <= r_acc ^ {64'd0, 25'd0, r_total, 3'd0};
                end
            end
        endcase
        if (r_state == ST_IDLE && n_state == ST_GH_LEN) begin
            r_z <= '0;
            r_v <= r_h;
            r_y <= r_acc ^ {64'd0, 25'd0, r_total, 3'd0};
        end
    end

`include "assert_macros.svh"
    `CHK_IMPL(a_pop_ok, i_clk, i_rst_n, o_req_pop, !i_req_empty, "pop of empty request queue")
    `CHK_IMPL(a_tag_full, i_clk, i_rst_n, o_res_push && o_res[1], o_res[6:2] == 5'd16, "tag bytes")
endmodule

@@ rtl/core/sm4_gcm_encrypt_tag.sv @@
// ----------------------------------------------------------------------------
// sm4_gcm_encrypt_tag
// SM4-GCM encryptor with 96-bit IV and no AAD; emits ciphertext and tag.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An item that carries data goes through
// loading the counter block, 32 SM4 rounds, 128 steps of the bit-serial
// GHASH multiplier and the hand-over of the result. The last item adds 128
// steps for the length block and the hand-over of the tag. The first item of
// a message also runs the 32-round key expansion and two 32-round encryptions
// (H and E(J0)). A zero-count item that is not last is popped straight from
// idle unless it starts a message. One SM4 round or GHASH bit step runs per
// cycle; a full result queue stalls the hand-over. A two-entry request queue
// lets the input side run ahead; a two-entry result queue decouples the output.
module sm4_gcm_encrypt_tag
    import sgcm_pkg::*;
#(
    parameter int QueueDepth = FifoDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic [4:0]  i_byte_count,
    input  logic        i_last_block,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_out_high,
    output logic [63:0] o_out_low,
    output logic [4:0]  o_out_bytes,
    output logic        o_result_kind,
    output logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic [63:0] r_key_high, r_key_low, r_iv_high;
    logic [31:0] r_iv_low;
    logic        w_req_push, w_req_full, w_req_empty, w_req_pop;
    t_req        w_req_in, w_req_out;
    logic        w_res_push, w_res_full;
    logic [ResW-1:0] w_res_in, w_res_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
        end else if (i_cfg_we) begin
            case ({2'b00, i_cfg_index})
                IdxKeyHigh: r_key_high <= i_cfg_data;
                IdxKeyLow:  r_key_low  <= i_cfg_data;
                IdxIvHigh:  r_iv_high  <= i_cfg_data;
                IdxIvLow:   r_iv_low   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    sgcm_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_data_high, .i_data_low, .i_byte_count, .i_last_block,
        .o_req_push(w_req_push), .o_req(w_req_in), .i_req_full(w_req_full)
    );

    sgcm_fifo #(.Width($bits(t_req)), .Depth(QueueDepth)) u_req_q (
        .i_clk, .i_rst_n, .i_push(w_req_push), .i_data(w_req_in), .o_full(w_req_full),
        .i_pop(w_req_pop), .o_data(w_req_out), .o_empty(w_req_empty)
    );

    sgcm_back u_back (
        .i_clk, .i_rst_n,
        .i_key_high(r_key_high), .i_key_low(r_key_low),
        .i_iv_high(r_iv_high), .i_iv_low(r_iv_low),
        .i_req_empty(w_req_empty), .i_req(w_req_out), .o_req_pop(w_req_pop),
        .o_res_push(w_res_push), .o_res(w_res_in), .i_res_full(w_res_full)
    );

    sgcm_fifo #(.Width(ResW), .Depth(QueueDepth)) u_res_q (
        .i_clk, .i_rst_n, .i_push(w_res_push), .i_data(w_res_in), .o_full(w_res_full),
        .i_pop(pop), .o_data(w_res_out), .o_empty(empty)
    );

    assign {o_out_high, o_out_low, o_out_bytes, o_result_kind, o_last_result} = w_res_out;

`include "assert_macros.svh"
    `CHK_IMPL(a_tag_last, i_clk, i_rst_n, !empty && o_result_kind, o_last_result, "tag not last")
endmodule
